/* hdl/binary_run_length_text_encoder_macros.svh */
// Assertion macros for the run-length text encoder checker.
// Each expects clk and arst_n in the scope where it is used.
`ifndef BINARY_RUN_LENGTH_TEXT_ENCODER_MACROS_SVH
`define BINARY_RUN_LENGTH_TEXT_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BRLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define BRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/brle_pkg.sv */
`timescale 1ns / 1ps

package brle_pkg;

	// Run counter and configuration widths
	localparam int RUN_BITS    = 32;
	localparam int MAX_MIN_RUN = 32;
	localparam int CFG_W       = 6;
	localparam int CHAR_W      = 8;

	// Decimal digits of the largest count: floor(RUN_BITS * log10(2)) + 1
	localparam int RUN_DIGITS  = (RUN_BITS * 30103) / 100000 + 1;
	localparam int BCD_W       = 4 * RUN_DIGITS;
	localparam int DIG_IDX_W   = $clog2(RUN_DIGITS);
	localparam int CNT_W       = $clog2(RUN_BITS + 1);
	localparam int CMP_W       = (RUN_BITS > CFG_W) ? RUN_BITS : CFG_W;

	localparam logic [RUN_BITS-1:0] RUN_MAX   = '1;
	localparam logic [CFG_W-1:0]    MIN_RUN_RST = CFG_W'(4);

	// Characters of the encoding
	localparam logic [CHAR_W-1:0] CH_AT   = 8'h40;
	localparam logic [CHAR_W-1:0] CH_A    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_B    = 8'h62;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;

	// Which character the datapath loads into the output register
	localparam logic [2:0] EMIT_NONE = 3'd0;
	localparam logic [2:0] EMIT_LIT  = 3'd1;
	localparam logic [2:0] EMIT_AT   = 3'd2;
	localparam logic [2:0] EMIT_DIG  = 3'd3;
	localparam logic [2:0] EMIT_SUF  = 3'd4;

	typedef logic [2:0] emit_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic      accept;
		emit_sel_t emit;
		logic      run_end;
		logic      load_pend;
		logic      conv_load;
		logic      conv_step;
	} brle_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_job;
		logic slot_free;
		logic lit_form;
		logic lit_last;
		logic conv_last;
		logic dig_last;
		logic pend_b;
	} brle_stat_t;

endpackage

/* hdl/brle_ifs.sv */
`timescale 1ns / 1ps

// Input bit channel
interface brle_bit_if;
	logic valid;
	logic ready;
	logic bit_value;
	logic stream_last;

	modport source (output valid, output bit_value, output stream_last, input ready);
	modport sink (input valid, input bit_value, input stream_last, output ready);
endinterface

// Output character channel
interface brle_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       item_done;
	logic       stream_end;
	logic       run_saturated;

	modport source (output valid, output out_char, output item_done, output stream_end,
		output run_saturated, input ready);
	modport sink (input valid, input out_char, input item_done, input stream_end,
		input run_saturated, output ready);
endinterface

// Configuration write channel
interface brle_cfg_if;
	logic       valid;
	logic       ready;
	logic [5:0] min_run;

	modport source (output valid, output min_run, input ready);
	modport sink (input valid, input min_run, output ready);
endinterface

/* hdl/brle_datapath.sv */
`timescale 1ns / 1ps

module brle_datapath import brle_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         bit_value,
	input  logic         stream_last,
	input  brle_cmd_t    cmd,
	output brle_stat_t   stat,
	brle_char_if.source  char_ch,
	brle_cfg_if.sink     cfg
);

	// Run state
	logic                 cur_q;
	logic [RUN_BITS-1:0]  len_q;
	logic                 clamp_q;
	logic                 at_start_q;
	logic                 last_q;
	logic                 pend_b_q;
	logic [CFG_W-1:0]     min_run_q;

	// Run being emitted
	logic                 e_bit_q;
	logic [RUN_BITS-1:0]  e_len_q;
	logic                 e_sat_q;
	logic                 e_lit_q;

	// Binary to decimal conversion
	logic [RUN_BITS-1:0]  bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIG_IDX_W-1:0] dig_idx_q;

	// Output register
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic                 out_done_q;
	logic                 out_end_q;
	logic                 out_sat_q;

	logic                 same_c;
	logic                 change_c;
	logic                 nxt_cur;
	logic [RUN_BITS-1:0]  nxt_len;
	logic                 nxt_clamp;
	logic [CFG_W-1:0]     m_eff;
	logic [BCD_W-1:0]     bcd_adj;
	logic [DIG_IDX_W-1:0] top_dig;
	logic [3:0]           cur_dig;
	logic                 done_c;

	// Next run state for an accepted bit
	always_comb begin
		same_c   = !at_start_q && (bit_value == cur_q);
		change_c = !at_start_q && (bit_value != cur_q);
		if (same_c) begin
			nxt_cur = cur_q;
			if (len_q == RUN_MAX) begin
				nxt_len   = len_q;
				nxt_clamp = 1'b1;
			end else begin
				nxt_len   = len_q + RUN_BITS'(1);
				nxt_clamp = clamp_q;
			end
		end else begin
			nxt_cur   = bit_value;
			nxt_len   = RUN_BITS'(1);
			nxt_clamp = 1'b0;
		end
	end

	// Effective threshold: zero acts as one, capped at MAX_MIN_RUN (32)
	always_comb begin
		if (min_run_q == '0) begin
			m_eff = CFG_W'(1);
		end else if (min_run_q > CFG_W'(MAX_MIN_RUN)) begin
			m_eff = CFG_W'(MAX_MIN_RUN);
		end else begin
			m_eff = min_run_q;
		end
	end

	// Double-dabble adjust: add 3 to every digit of 5 or more
	always_comb begin
		for (int i = 0; i < RUN_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Highest nonzero digit; the count is never zero here
	always_comb begin
		top_dig = '0;
		for (int i = 0; i < RUN_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				top_dig = DIG_IDX_W'(i);
			end
		end
	end

	assign cur_dig = bcd_q[dig_idx_q*4 +: 4];
	assign done_c  = cmd.run_end && !pend_b_q;

	// Status
	always_comb begin
		stat.in_job    = change_c || stream_last;
		stat.slot_free = !out_valid_q || char_ch.ready;
		stat.lit_form  = e_lit_q || (CMP_W'(e_len_q) < CMP_W'(m_eff));
		stat.lit_last  = (e_len_q == RUN_BITS'(1));
		stat.conv_last = (cnt_q == CNT_W'(1));
		stat.dig_last  = (dig_idx_q == '0);
		stat.pend_b    = pend_b_q;
	end

	// Configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q <= MIN_RUN_RST;
		end else if (cfg.valid) begin
			min_run_q <= cfg.min_run;
		end
	end

	// Run state and pending work
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q      <= 1'b0;
			len_q      <= '0;
			clamp_q    <= 1'b0;
			at_start_q <= 1'b1;
			last_q     <= 1'b0;
			pend_b_q   <= 1'b0;
		end else if (cmd.accept) begin
			cur_q      <= nxt_cur;
			len_q      <= nxt_len;
			clamp_q    <= nxt_clamp;
			at_start_q <= stream_last;
			last_q     <= stream_last;
			pend_b_q   <= change_c && stream_last;
		end else if (cmd.load_pend) begin
			pend_b_q   <= 1'b0;
		end
	end

	// Emission run, literal countdown and conversion
	always_ff @(posedge clk) begin
		if (cmd.emit == EMIT_AT) begin
			dig_idx_q <= top_dig;
		end
		if (cmd.emit == EMIT_DIG) begin
			dig_idx_q <= dig_idx_q - DIG_IDX_W'(1);
		end
		if (cmd.conv_load) begin
			bin_q <= e_len_q;
			bcd_q <= '0;
			cnt_q <= CNT_W'(RUN_BITS);
		end else if (cmd.conv_step) begin
			{bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
			cnt_q          <= cnt_q - CNT_W'(1);
		end
		if (cmd.accept) begin
			if (change_c) begin
				e_bit_q <= cur_q;
				e_len_q <= len_q;
				e_sat_q <= clamp_q;
				e_lit_q <= 1'b0;
			end else begin
				e_bit_q <= nxt_cur;
				e_len_q <= nxt_len;
				e_sat_q <= nxt_clamp;
				e_lit_q <= at_start_q;
			end
		end else if (cmd.load_pend) begin
			e_bit_q <= cur_q;
			e_len_q <= len_q;
			e_sat_q <= clamp_q;
			e_lit_q <= 1'b0;
		end else if (cmd.emit == EMIT_LIT) begin
			e_len_q <= e_len_q - RUN_BITS'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (char_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.emit != EMIT_NONE) begin
			out_done_q <= done_c;
			out_end_q  <= done_c && last_q;
			out_sat_q  <= e_sat_q;
		end
		case (cmd.emit)
			EMIT_LIT: out_char_q <= CH_ZERO | {7'b0, e_bit_q};
			EMIT_AT:  out_char_q <= CH_AT;
			EMIT_DIG: out_char_q <= CH_ZERO | {4'b0, cur_dig};
			EMIT_SUF: out_char_q <= e_bit_q ? CH_B : CH_A;
			default:  out_char_q <= out_char_q;
		endcase
	end

	assign char_ch.valid         = out_valid_q;
	assign char_ch.out_char      = out_char_q;
	assign char_ch.item_done     = out_done_q;
	assign char_ch.stream_end    = out_end_q;
	assign char_ch.run_saturated = out_sat_q;

endmodule

/* hdl/brle_ctrl.sv */
`timescale 1ns / 1ps

module brle_ctrl import brle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  brle_stat_t stat,
	output brle_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_LIT   = 3'd2;
	localparam logic [2:0] S_CONV  = 3'd3;
	localparam logic [2:0] S_AT    = 3'd4;
	localparam logic [2:0] S_DIG   = 3'd5;
	localparam logic [2:0] S_SUF   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cmd.accept    = 1'b0;
		cmd.emit      = EMIT_NONE;
		cmd.run_end   = 1'b0;
		cmd.load_pend = 1'b0;
		cmd.conv_load = 1'b0;
		cmd.conv_step = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.in_job) begin
						state_d = S_START;
					end
				end
			end
			S_START: begin
				if (stat.lit_form) begin
					state_d = S_LIT;
				end else begin
					cmd.conv_load = 1'b1;
					state_d       = S_CONV;
				end
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (stat.conv_last) begin
					state_d = S_AT;
				end
			end
			S_AT: begin
				if (stat.slot_free) begin
					cmd.emit = EMIT_AT;
					state_d  = S_DIG;
				end
			end
			S_DIG: begin
				if (stat.slot_free) begin
					cmd.emit = EMIT_DIG;
					if (stat.dig_last) begin
						state_d = S_SUF;
					end
				end
			end
			S_SUF: begin
				if (stat.slot_free) begin
					cmd.emit    = EMIT_SUF;
					cmd.run_end = 1'b1;
				end
			end
			S_LIT: begin
				if (stat.slot_free) begin
					cmd.emit = EMIT_LIT;
					if (stat.lit_last) begin
						cmd.run_end = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// End of a run: start the final run of the item or go idle
		if (cmd.run_end) begin
			if (stat.pend_b) begin
				cmd.load_pend = 1'b1;
				state_d       = S_START;
			end else begin
				state_d = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/binary_run_length_text_encoder.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// bit_ch    in   valid/ready    bit_value, stream_last
// char_ch   out  valid/ready    out_char, item_done, stream_end, run_saturated
// cfg       in   valid/ready    min_run (always ready)
//
// A bit that only extends a run is taken straight from the idle state. Each run that
// ends then passes through a setup state and either the literal characters or, for
// the @count form, a shift-add-3 conversion of all RUN_BITS bits and then the characters.
// Runs are emitted one character a cycle through a single output register; a stall
// on char_ch holds the controller, and bit_ch is ready only when no run is pending.
// Reset (arst_n low) clears run state, empties the output and sets min_run to 4.

module binary_run_length_text_encoder import brle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	brle_bit_if.sink    bit_ch,
	brle_char_if.source char_ch,
	brle_cfg_if.sink    cfg
);

	brle_cmd_t  cmd;
	brle_stat_t stat;
	logic       in_ready;

	assign bit_ch.ready = in_ready;

	brle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bit_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	brle_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.bit_value   (bit_ch.bit_value),
		.stream_last (bit_ch.stream_last),
		.cmd         (cmd),
		.stat        (stat),
		.char_ch     (char_ch),
		.cfg         (cfg)
	);

endmodule

/* hdl/brle_checker.sv */
`timescale 1ns / 1ps
`include "binary_run_length_text_encoder_macros.svh"

module brle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       item_done,
	input logic       stream_end,
	input logic       run_saturated
);

	// A stalled character holds
	`BRLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(item_done) && $stable(stream_end) && $stable(run_saturated), "stalled character changed")

	// The end of the encoding is always the end of an item
	`BRLE_ASSERT_NOW(a_end_done, out_valid && stream_end, item_done, "stream_end without item_done")

	// Only digits, '@', 'a' and 'b' appear
	`BRLE_ASSERT_NOW(a_char_legal, out_valid, ((out_char >= 8'h30) && (out_char <= 8'h39)) || (out_char == 8'h40) || (out_char == 8'h61) || (out_char == 8'h62), "illegal character")

	// A count prefix never closes an item
	`BRLE_ASSERT_NOW(a_at_open, out_valid && (out_char == 8'h40), !item_done, "item ends on '@'")

endmodule

bind binary_run_length_text_encoder brle_checker u_brle_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (char_ch.valid),
	.out_ready     (char_ch.ready),
	.out_char      (char_ch.out_char),
	.item_done     (char_ch.item_done),
	.stream_end    (char_ch.stream_end),
	.run_saturated (char_ch.run_saturated)
);

/* tb/sv/binary_run_length_text_encoder_tb.sv */
`timescale 1ns / 1ps

module binary_run_length_text_encoder_tb import brle_pkg::*; ();

	localparam int RANDOM_ITEMS = 500;
	localparam int PHASE_ITEMS  = 60;
	localparam int IDLE_PCT     = 37;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = RUN_BITS + 16;
	localparam int STALL_LIMIT  = 4000;

	// One output character with its flags
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              done;
		logic              fin;
		logic              sat;
	} rle_char_t;

	// Tracks the encoder state and the characters still owed by the block
	class rle_encoding_check;
		logic [CFG_W-1:0]    min_run = MIN_RUN_RST;
		logic                cur_bit = 1'b0;
		logic [RUN_BITS-1:0] run_len = '0;
		bit                  at_start = 1'b1;
		bit                  run_clamped = 1'b0;
		rle_char_t           step_chars[$];
		rle_char_t           pending_chars[$];
		int                  errors = 0;

		function void add_char(logic [CHAR_W-1:0] c);
			if (step_chars.size() < 32)
				step_chars.push_back('{ch: c, done: 1'b0, fin: 1'b0, sat: run_clamped});
		endfunction

		// Text for the run that just closed
		function void emit_run();
			int unsigned m;
			int unsigned i;
			logic [RUN_BITS-1:0] v;
			byte unsigned dg[$];
			m = min_run;
			if (m < 1)
				m = 1;
			if (m > MAX_MIN_RUN)
				m = MAX_MIN_RUN;
			if (run_len < m) begin
				for (i = 0; i < run_len; i++)
					add_char(CH_ZERO + cur_bit);
			end else begin
				v = run_len;
				do begin
					dg.push_front(8'(v % 10));
					v = v / 10;
				end while (v != 0);
				add_char(CH_AT);
				foreach (dg[k])
					add_char(CH_ZERO + dg[k]);
				add_char(cur_bit ? CH_B : CH_A);
			end
		endfunction

		// Accepted input item: advance state, queue the characters it causes
		function void take_bit(logic b, logic last);
			if (at_start) begin
				cur_bit = b;
				run_len = 1;
				run_clamped = 1'b0;
				at_start = 1'b0;
				if (last) begin
					add_char(CH_ZERO + b);
					at_start = 1'b1;
					run_len = '0;
				end
			end else begin
				if (b == cur_bit) begin
					if (run_len == RUN_MAX)
						run_clamped = 1'b1;
					else
						run_len++;
				end else begin
					emit_run();
					cur_bit = b;
					run_len = 1;
					run_clamped = 1'b0;
				end
				if (last) begin
					emit_run();
					at_start = 1'b1;
					run_len = '0;
					run_clamped = 1'b0;
				end
			end
			foreach (step_chars[k]) begin
				step_chars[k].done = (k == step_chars.size() - 1);
				step_chars[k].fin  = step_chars[k].done && last;
				pending_chars.push_back(step_chars[k]);
			end
			step_chars.delete();
		endfunction

		// Accepted output character against the oldest one owed
		function void check_char(rle_char_t got);
			rle_char_t exp;
			if (pending_chars.size() == 0) begin
				if (errors < 10)
					$display("unexpected char %h done %b end %b sat %b",
						got.ch, got.done, got.fin, got.sat);
				errors++;
			end else begin
				exp = pending_chars.pop_front();
				if (got.ch !== exp.ch || got.done !== exp.done ||
						got.fin !== exp.fin || got.sat !== exp.sat) begin
					if (errors < 10)
						$display("char mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
							exp.ch, exp.done, exp.fin, exp.sat,
							got.ch, got.done, got.fin, got.sat);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	brle_bit_if  bit_ch();
	brle_char_if char_ch();
	brle_cfg_if  cfg_ch();

	binary_run_length_text_encoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bit_ch  (bit_ch),
		.char_ch (char_ch),
		.cfg     (cfg_ch)
	);

	rle_encoding_check enc;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int stall_cycles = 0;
	int phase_min[8] = '{1, 0, 32, 63, 2, 31, 33, 9};

	// Clock, 8 ns period
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Monitor: accepted items on every channel, stall counting
	always @(posedge clk) begin : monitor
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (bit_ch.valid && bit_ch.ready) begin
				enc.take_bit(bit_ch.bit_value, bit_ch.stream_last);
				moved = 1'b1;
			end
			if (char_ch.valid && char_ch.ready) begin
				enc.check_char('{ch: char_ch.out_char, done: char_ch.item_done,
					fin: char_ch.stream_end, sat: char_ch.run_saturated});
				moved = 1'b1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				enc.min_run = cfg_ch.min_run;
				moved = 1'b1;
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
		end
	end

	// Receiver: random backpressure, one long hold-off on request
	initial begin
		char_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				char_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			char_ch.ready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Watchdog
	initial begin
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

	// Offer one bit item; called at a falling edge, returns at one
	task automatic send_bit(input bit b, input bit last);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			bit_ch.valid = 1'b0;
			bit_ch.bit_value = 1'($urandom);
			bit_ch.stream_last = 1'($urandom);
			@(negedge clk);
		end
		bit_ch.valid = 1'b1;
		bit_ch.bit_value = b;
		bit_ch.stream_last = last;
		do @(posedge clk); while (!bit_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_run(input bit b, input int len, input bit last);
		int i;
		for (i = 0; i < len; i++)
			send_bit(b, last && (i == len - 1));
	endtask

	// Stop offering, wait for every owed char, then let the block go quiet
	task automatic quiesce();
		bit_ch.valid = 1'b0;
		while (enc.pending_chars.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_min_run(input logic [CFG_W-1:0] v);
		cfg_ch.valid = 1'b1;
		cfg_ch.min_run = v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// One stream: mostly runs of chosen lengths, sometimes raw random bits
	task automatic send_stream();
		int nruns;
		int len;
		int r;
		int pick;
		bit b;
		if ($urandom_range(0, 9) == 0) begin
			nruns = $urandom_range(1, 20);
			for (r = 0; r < nruns; r++)
				send_bit(1'($urandom), (r == nruns - 1) || ($urandom_range(0, 7) == 0));
		end else begin
			nruns = $urandom_range(1, 6);
			b = 1'($urandom);
			for (r = 0; r < nruns; r++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					len = $urandom_range(1, 8);
				else if (pick < 93)
					len = $urandom_range(9, 40);
				else
					len = $urandom_range(41, 130);
				send_run(b, len, r == nruns - 1);
				b = !b;
			end
		end
	endtask

	initial begin : main
		int phase;
		int budget;
		int streams;
		enc = new();
		arst_n = 1'b0;
		bit_ch.valid = 1'b0;
		bit_ch.bit_value = 1'b0;
		bit_ch.stream_last = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.min_run = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: single-bit streams, literal run, @count runs, run change at last
		send_bit(1'b0, 1'b1);
		send_bit(1'b1, 1'b1);
		send_run(1'b1, 3, 1'b1);
		send_run(1'b0, 4, 1'b1);
		send_bit(1'b0, 1'b0);
		send_bit(1'b1, 1'b1);
		send_run(1'b1, 12, 1'b1);
		quiesce();

		// Random phases, each with its own min_run
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			write_min_run(CFG_W'(phase < 8 ? phase_min[phase] : $urandom_range(0, 63)));
			no_idle = (phase == 2);
			if (phase == 3)
				hold_req = 1'b1;
			budget = items_sent + PHASE_ITEMS;
			if (budget > RANDOM_ITEMS)
				budget = RANDOM_ITEMS;
			streams = 0;
			while (items_sent < budget) begin
				// sender waits for every owed char once, between streams
				if (phase == 4 && streams == 2)
					quiesce();
				send_stream();
				streams++;
			end
			quiesce();
			no_idle = 1'b0;
			phase++;
		end

		if (enc.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* binary_run_length_text_encoder.f */
+incdir+hdl
hdl/brle_pkg.sv
hdl/brle_ifs.sv
hdl/brle_datapath.sv
hdl/brle_ctrl.sv
hdl/binary_run_length_text_encoder.sv
hdl/brle_checker.sv
tb/sv/binary_run_length_text_encoder_tb.sv
